// ----- rtl/wftp_pkg.sv -----
// wftp_pkg: shared types, widths and the priority-to-weight table
// for the weighted fair thread picker; no dependencies
package wftp_pkg;

  localparam int DEF_TABLE_DEPTH   = 16;
  localparam int DEF_LATENCY_TICKS = 48;

  localparam int ID_W    = 8;
  localparam int PRIO_W  = 2;
  localparam int SVC_W   = 16;
  localparam int VRT_W   = 23;
  localparam int ARR_W   = 16;
  localparam int WGT_W   = 17;
  localparam int SLICE_W = 8;
  localparam int QCNT_W  = 5;
  localparam int LAT_W   = 8;
  localparam int GRAN_W  = 8;

  // dividend covers 1024*svc_ticks and latency*weight
  localparam int DVD_W     = 26;
  localparam int VRT_SHIFT = 10;
  localparam int WGT_MAX   = 88761;

  localparam logic [GRAN_W-1:0] MIN_GRAN_RESET = 8'd3;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_SELECT = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ID_W-1:0]   thread_id;
    logic [PRIO_W-1:0] thread_priority;
    logic [SVC_W-1:0]  svc_ticks;
    logic              is_ready;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [ID_W-1:0]    picked_id;
    logic [SLICE_W-1:0] slice_ticks;
    logic [VRT_W-1:0]   picked_vruntime;
    logic [QCNT_W-1:0]  queued_count;
    logic               overflowed;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   thread;
    logic [PRIO_W-1:0] weight_class;
    logic [VRT_W-1:0]  vruntime;
    logic [ARR_W-1:0]  arrival;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } store_ctl_t;

  function automatic logic [WGT_W-1:0] weight_of(input logic [PRIO_W-1:0] cls);
    logic [WGT_W-1:0] w;
    case (cls)
      2'd0:    w = 17'd88761;
      2'd1:    w = 17'd29154;
      2'd2:    w = 17'd1024;
      default: w = 17'd15;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/wftp_div.sv -----
// wftp_div: restoring serial divider, one quotient bit per cycle
// depends on nothing but its parameters
module wftp_div #(
  parameter int DVD_W = 26,
  parameter int DSR_W = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CW = $clog2(DVD_W + 1);
  localparam logic [CW-1:0] CNT_INIT = CW'(DVD_W);

  logic             busy_q;
  logic [CW-1:0]    cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DSR_W-1:0] rem_q;
  logic [DSR_W-1:0] dsr_q;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_INIT;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/wftp_store.sv -----
// wftp_store: ready table entries in a synchronous memory plus per-entry valid bits
// depends on wftp_pkg
module wftp_store #(
  parameter int TABLE_DEPTH = 16,
  parameter int IDX_W       = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wftp_pkg::store_ctl_t ctl_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  input  logic [IDX_W-1:0]     wr_addr_i,
  input  logic [IDX_W-1:0]     clr_addr_i,
  input  wftp_pkg::entry_t     wr_data_i,
  output wftp_pkg::entry_t     rd_data_o,
  output logic                 rd_valid_o,
  output logic [TABLE_DEPTH-1:0] valid_o
);
  import wftp_pkg::*;

  entry_t                 mem_q [TABLE_DEPTH];
  entry_t                 rd_data_q;
  logic                   rd_valid_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.clr_en) begin
        valid_q[clr_addr_i] <= 1'b0;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;
  assign valid_o    = valid_q;

endmodule

// ----- rtl/weighted_fair_thread_picker_unit.sv -----
// weighted_fair_thread_picker_unit: ready table with least-vruntime pick and weighted slice
// add: entry written once the serial vruntime divide is done and a free slot is found
// select: result registered after one memory read per entry, a multiply and a divide;
//   an empty select goes straight to done, an ignored or dropped add leaves the picker idle
// input is taken again in the cycle after an item retires; a held result stalls the select in done
// reset is asynchronous active low: table empty, counters cleared, slice floor 3
module weighted_fair_thread_picker_unit #(
  parameter int TABLE_DEPTH   = wftp_pkg::DEF_TABLE_DEPTH,
  parameter int LATENCY_TICKS = wftp_pkg::DEF_LATENCY_TICKS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wftp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wftp_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i
);
  import wftp_pkg::*;

  // table geometry and arithmetic widths
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int WTOT_W = $clog2(WGT_MAX * TABLE_DEPTH + 1);
  localparam int DEN_W  = WTOT_W + CNT_W;
  localparam int NUM_W  = LAT_W + WGT_W;
  localparam int DSR_W  = (DEN_W > WGT_W) ? DEN_W : WGT_W;

  localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(TABLE_DEPTH);
  localparam logic [IDX_W:0]   DEPTH_SCAN = (IDX_W + 1)'(TABLE_DEPTH);
  localparam logic [LAT_W-1:0] LAT_C      = LAT_W'(LATENCY_TICKS);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ADD   = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_START = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  // control state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [WTOT_W-1:0]  wtot_q, wtot_d;
  logic [ARR_W-1:0]   arr_q, arr_d;
  logic               drop_q, drop_d;
  logic [GRAN_W-1:0]  min_gran_q, min_gran_d;
  logic               out_valid_q, out_valid_d;
  logic [IDX_W:0]     scan_q, scan_d;
  logic               slot_ok_q, slot_ok_d;
  logic               pend_q, pend_d;
  logic               have_q, have_d;

  // payload
  in_item_t           item_q, item_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [VRT_W-1:0]   best_vrt_q, best_vrt_d;
  logic [ARR_W-1:0]   best_age_q, best_age_d;
  logic [ID_W-1:0]    best_thr_q, best_thr_d;
  logic [PRIO_W-1:0]  best_cls_q, best_cls_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [DEN_W-1:0]   den_q, den_d;
  out_item_t          res_q, res_d;
  out_item_t          out_item_q, out_item_d;

  // datapath wires
  logic               in_xfer;
  store_ctl_t         st_ctl;
  entry_t             wr_entry;
  entry_t             rd_entry;
  logic               rd_valid;
  logic [TABLE_DEPTH-1:0] valid_vec;
  logic               div_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [DSR_W-1:0]   div_dsr;
  logic               div_busy;
  logic [DVD_W-1:0]   div_quo;
  logic [ARR_W-1:0]   rd_age;
  logic               rd_better;
  logic [NUM_W-1:0]   num_full;
  logic [DEN_W-1:0]   den_full;
  logic [SLICE_W-1:0] slice_raw;
  logic [WGT_W-1:0]   best_wgt;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // age relative to the arrival counter, wraps mod 2^16
  assign rd_age    = arr_q - rd_entry.arrival;
  assign rd_better = !have_q || (rd_entry.vruntime < best_vrt_q) ||
                     ((rd_entry.vruntime == best_vrt_q) && (rd_age > best_age_q));

  assign best_wgt  = weight_of(best_cls_q);
  assign num_full  = LAT_C * best_wgt;
  assign den_full  = wtot_q * count_q;
  assign slice_raw = div_quo[SLICE_W-1:0];

  // new entry goes into the free slot found by the scan
  always_comb begin
    wr_entry              = '0;
    wr_entry.thread       = item_q.thread_id;
    wr_entry.weight_class = item_q.thread_priority;
    wr_entry.vruntime     = div_quo[VRT_W-1:0];
    wr_entry.arrival      = arr_q;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    wtot_d      = wtot_q;
    arr_d       = arr_q;
    drop_d      = drop_q;
    min_gran_d  = min_gran_q;
    out_valid_d = out_valid_q;
    scan_d      = scan_q;
    slot_ok_d   = slot_ok_q;
    pend_d      = pend_q;
    have_d      = have_q;
    item_d      = item_q;
    pend_idx_d  = pend_idx_q;
    best_idx_d  = best_idx_q;
    best_vrt_d  = best_vrt_q;
    best_age_d  = best_age_q;
    best_thr_d  = best_thr_q;
    best_cls_d  = best_cls_q;
    num_d       = num_q;
    den_d       = den_q;
    res_d       = res_q;
    out_item_d  = out_item_q;
    st_ctl      = '0;
    div_start   = 1'b0;
    div_dvd     = DVD_W'(num_q);
    div_dsr     = DSR_W'(den_q);

    if (cfg_we_i) begin
      min_gran_d = cfg_data_i;
    end
    // output register drains independently of the engine
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          item_d = in_item_i;
          if (in_item_i.req_type == REQ_ADD) begin
            // not-ready threads are ignored outright
            if (in_item_i.is_ready) begin
              if (count_q >= DEPTH_CNT) begin
                drop_d = 1'b1;
              end else begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(in_item_i.svc_ticks) << VRT_SHIFT;
                div_dsr   = DSR_W'(weight_of(in_item_i.thread_priority));
                scan_d    = '0;
                slot_ok_d = 1'b0;
                state_d   = ST_ADD;
              end
            end
          end else begin
            if (count_q == '0) begin
              // empty table: answer with found cleared
              res_d            = '0;
              res_d.overflowed = drop_q;
              state_d          = ST_DONE;
            end else begin
              scan_d  = '0;
              pend_d  = 1'b0;
              have_d  = 1'b0;
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_ADD: begin
        // lowest free slot, searched one valid bit per cycle during the divide
        if (!slot_ok_q) begin
          if (!valid_vec[scan_q[IDX_W-1:0]]) begin
            slot_ok_d = 1'b1;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end else if (!div_busy) begin
          st_ctl.wr_en = 1'b1;
          arr_d        = arr_q + 1'b1;
          wtot_d       = wtot_q + WTOT_W'(weight_of(item_q.thread_priority));
          count_d      = count_q + 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // read issue, then compare in the next cycle
        if (scan_q != DEPTH_SCAN) begin
          st_ctl.rd_en = 1'b1;
          scan_d       = scan_q + 1'b1;
        end
        pend_d     = (scan_q != DEPTH_SCAN);
        pend_idx_d = scan_q[IDX_W-1:0];
        if (pend_q && rd_valid && rd_better) begin
          have_d     = 1'b1;
          best_idx_d = pend_idx_q;
          best_vrt_d = rd_entry.vruntime;
          best_age_d = rd_age;
          best_thr_d = rd_entry.thread;
          best_cls_d = rd_entry.weight_class;
        end
        if ((scan_q == DEPTH_SCAN) && !pend_q) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        num_d   = num_full;
        den_d   = den_full;
        state_d = ST_START;
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          res_d.found           = 1'b1;
          res_d.picked_id       = best_thr_q;
          res_d.slice_ticks     = (slice_raw < min_gran_q) ? min_gran_q : slice_raw;
          res_d.picked_vruntime = best_vrt_q;
          res_d.queued_count    = QCNT_W'(count_q);
          res_d.overflowed      = drop_q;
          state_d               = ST_DONE;
        end
      end
      ST_DONE: begin
        // retire the pick when the output register can take the result
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_item_d  = res_q;
          if (res_q.found) begin
            st_ctl.clr_en = 1'b1;
            wtot_d        = wtot_q - WTOT_W'(best_wgt);
            count_d       = count_q - 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      wtot_q      <= '0;
      arr_q       <= '0;
      drop_q      <= 1'b0;
      min_gran_q  <= MIN_GRAN_RESET;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      slot_ok_q   <= 1'b0;
      pend_q      <= 1'b0;
      have_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wtot_q      <= wtot_d;
      arr_q       <= arr_d;
      drop_q      <= drop_d;
      min_gran_q  <= min_gran_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
      slot_ok_q   <= slot_ok_d;
      pend_q      <= pend_d;
      have_q      <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    pend_idx_q <= pend_idx_d;
    best_idx_q <= best_idx_d;
    best_vrt_q <= best_vrt_d;
    best_age_q <= best_age_d;
    best_thr_q <= best_thr_d;
    best_cls_q <= best_cls_d;
    num_q      <= num_d;
    den_q      <= den_d;
    res_q      <= res_d;
    out_item_q <= out_item_d;
  end

  wftp_store #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (st_ctl),
    .rd_addr_i (scan_q[IDX_W-1:0]),
    .wr_addr_i (scan_q[IDX_W-1:0]),
    .clr_addr_i(best_idx_q),
    .wr_data_i (wr_entry),
    .rd_data_o (rd_entry),
    .rd_valid_o(rd_valid),
    .valid_o   (valid_vec)
  );

  // shared by the vruntime and the slice computation
  wftp_div #(
    .DVD_W(DVD_W),
    .DSR_W(DSR_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dsr),
    .busy_o    (div_busy),
    .quotient_o(div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // occupancy never exceeds the table
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("entry count above table depth");

  // entry count tracks the valid bits
  a_count_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == count_q)
    else $error("entry count disagrees with valid bits");

  // a new transfer is only taken with the divider free
  a_idle_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !div_busy)
    else $error("input taken while divider busy");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking testbench for weighted_fair_thread_picker_unit
// depends on wftp_pkg and the picker rtl; predicts every pick and checks each result transfer

module tb_top;
  import wftp_pkg::*;

  localparam int          SETTLE_CYCLES = 64;    // longest op is a select
  localparam int          STUCK_LIMIT   = 4000;  // cycles without any transfer
  localparam int          HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int          MAX_PRINTS    = 40;
  localparam int unsigned WEIGHT_BY_CLASS [4] = '{88761, 29154, 1024, 15};

  // all block inputs start at known values
  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_we_i    = 1'b0;
  logic [GRAN_W-1:0]   cfg_data_i  = '0;

  // shadow of the ready table, updated on every accepted request
  bit                  slot_used [DEF_TABLE_DEPTH];
  logic [ID_W-1:0]     slot_id   [DEF_TABLE_DEPTH];
  logic [PRIO_W-1:0]   slot_cls  [DEF_TABLE_DEPTH];
  logic [VRT_W-1:0]    slot_vrt  [DEF_TABLE_DEPTH];
  logic [ARR_W-1:0]    slot_arr  [DEF_TABLE_DEPTH];
  logic [ARR_W-1:0]    arrival_stamp = '0;
  longint unsigned     weight_sum    = 0;
  int                  occupancy     = 0;
  bit                  sticky_drop   = 1'b0;
  logic [GRAN_W-1:0]   gran_model    = MIN_GRAN_RESET;

  out_item_t           pick_expect_q [$];
  int                  mismatch_count = 0;
  int                  stuck_cycles   = 0;

  // idling controls for the request side and the receiver process
  bit                  tx_calm     = 1'b0;
  bit                  rx_calm     = 1'b0;
  int                  rx_hold_len = 0;

  weighted_fair_thread_picker_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // prediction: mirror of the ready table
  // ---------------------------------------------------------------------------

  function automatic void predict_request(input in_item_t req);
    out_item_t        pick;
    int               best;
    int               slot;
    logic [ARR_W-1:0] age_cand;
    logic [ARR_W-1:0] age_best;
    longint unsigned  w;
    longint unsigned  span;
    longint unsigned  slice;
    if (req.req_type == REQ_ADD) begin
      // not-ready threads leave no trace
      if (!req.is_ready) return;
      // full table: drop the add, flag stays set until reset
      if (occupancy >= DEF_TABLE_DEPTH) begin
        sticky_drop = 1'b1;
        return;
      end
      slot = -1;
      for (int i = 0; i < DEF_TABLE_DEPTH; i++) begin
        if (!slot_used[i] && slot < 0) slot = i;
      end
      if (slot < 0) begin
        sticky_drop = 1'b1;
        return;
      end
      w = WEIGHT_BY_CLASS[req.thread_priority];
      slot_used[slot] = 1'b1;
      slot_id[slot]   = req.thread_id;
      slot_cls[slot]  = req.thread_priority;
      slot_vrt[slot]  = VRT_W'((64'd1024 * req.svc_ticks) / w);
      slot_arr[slot]  = arrival_stamp;
      arrival_stamp   = arrival_stamp + 1'b1;
      weight_sum     += w;
      occupancy++;
      return;
    end

    // select: least vruntime, ties to the oldest arrival (wrapped age)
    best = -1;
    for (int i = 0; i < DEF_TABLE_DEPTH; i++) begin
      if (slot_used[i]) begin
        if (best < 0) begin
          best = i;
        end else if (slot_vrt[i] < slot_vrt[best]) begin
          best = i;
        end else if (slot_vrt[i] == slot_vrt[best]) begin
          age_cand = arrival_stamp - slot_arr[i];
          age_best = arrival_stamp - slot_arr[best];
          if (age_cand > age_best) best = i;
        end
      end
    end

    pick = '0;
    pick.overflowed = sticky_drop;
    if (best >= 0 && occupancy != 0 && weight_sum != 0) begin
      // slice uses the totals from before the removal
      w     = WEIGHT_BY_CLASS[slot_cls[best]];
      span  = weight_sum * longint'(occupancy);
      slice = (longint'(DEF_LATENCY_TICKS) * w) / span;
      if (slice < gran_model) slice = gran_model;
      pick.found           = 1'b1;
      pick.picked_id       = slot_id[best];
      pick.slice_ticks     = SLICE_W'(slice);
      pick.picked_vruntime = slot_vrt[best];
      pick.queued_count    = QCNT_W'(occupancy);
      slot_used[best]      = 1'b0;
      weight_sum          -= w;
      occupancy--;
    end
    pick_expect_q.push_back(pick);
  endfunction

  // every accepted request goes through the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) predict_request(in_item_i);
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : pick_checker
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pick_expect_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_item_o, 0);
      end else begin
        want = pick_expect_q.pop_front();
        if (out_item_o.found !== want.found)
          report_mismatch("found", out_item_o.found, want.found);
        if (out_item_o.picked_id !== want.picked_id)
          report_mismatch("picked_id", out_item_o.picked_id, want.picked_id);
        if (out_item_o.slice_ticks !== want.slice_ticks)
          report_mismatch("slice_ticks", out_item_o.slice_ticks, want.slice_ticks);
        if (out_item_o.picked_vruntime !== want.picked_vruntime)
          report_mismatch("picked_vruntime", out_item_o.picked_vruntime,
                          want.picked_vruntime);
        if (out_item_o.queued_count !== want.queued_count)
          report_mismatch("queued_count", out_item_o.queued_count, want.queued_count);
        if (out_item_o.overflowed !== want.overflowed)
          report_mismatch("overflowed", out_item_o.overflowed, want.overflowed);
      end
    end
  end

  // hang detection: no transfer on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stall per transfer, long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : pick_receiver
    int hold;
    @(posedge clk_i);
    forever begin
      if (rx_hold_len > 0) begin
        hold        = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        hold = rx_calm ? 0 : $urandom_range(0, 9);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      // wait for the transfer, or leave early when a hold-off is asked for
      do @(posedge clk_i);
      while (!(out_valid_o && !out_stall_i) && rx_hold_len == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // called at a rising edge; returns at the edge where the transfer happened
  task automatic send_request(input in_item_t req);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i);
    while (in_stall_o);
  endtask

  // stop offering, let every pick come back, then let a trailing add finish
  task automatic settle_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pick_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_min_gran(input logic [GRAN_W-1:0] gran);
    settle_block();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= gran;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    gran_model  = gran;
  endtask

  function automatic in_item_t add_req(input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] prio,
                                       input logic [SVC_W-1:0] svc, input logic ready);
    in_item_t req;
    req.req_type        = REQ_ADD;
    req.thread_id       = id;
    req.thread_priority = prio;
    req.svc_ticks       = svc;
    req.is_ready        = ready;
    return req;
  endfunction

  function automatic in_item_t select_req();
    in_item_t req;
    req                 = in_item_t'({$urandom, $urandom});
    req.req_type        = REQ_SELECT;
    return req;
  endfunction

  // small service times make vruntime ties common, extremes show up often
  function automatic logic [SVC_W-1:0] random_service();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return SVC_W'($urandom_range(0, 127));
    if (roll < 45) return '0;
    if (roll < 50) return '1;
    return SVC_W'($urandom);
  endfunction

  function automatic in_item_t random_request(input int add_pct, input int idle_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < add_pct)
      return add_req(ID_W'($urandom), PRIO_W'($urandom), random_service(), 1'b1);
    if (roll < add_pct + idle_pct)
      return add_req(ID_W'($urandom), PRIO_W'($urandom), random_service(), 1'b0);
    return select_req();
  endfunction

  // sends until n requests that do something were transferred
  task automatic send_random_mix(input int n, input int add_pct, input int idle_pct);
    in_item_t req;
    int       done;
    done = 0;
    while (done < n) begin
      req = random_request(add_pct, idle_pct);
      send_request(req);
      if (!(req.req_type == REQ_ADD && !req.is_ready)) done++;
      // now and then the sender waits for every outstanding pick
      if ($urandom_range(0, 99) == 0) settle_block();
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_picks();
    // select on an empty table
    send_request(select_req());
    // extremes of id, class and service time
    send_request(add_req(8'h00, 2'd0, 16'h0000, 1'b1));
    send_request(add_req(8'hFF, 2'd3, 16'hFFFF, 1'b1));  // largest vruntime
    send_request(add_req(8'h5A, 2'd1, 16'hFFFF, 1'b1));
    send_request(add_req(8'hA5, 2'd2, 16'h0001, 1'b1));
    send_request(add_req(8'h33, 2'd0, 16'h0050, 1'b1));  // ties with the first add
    send_request(add_req(8'h77, 2'd2, 16'h0000, 1'b0));  // not ready, ignored
    repeat (6) send_request(select_req());                // drains, last one empty
    // tie inside one class, older arrival first
    send_request(add_req(8'h0F, 2'd1, 16'h0000, 1'b1));
    send_request(add_req(8'hF0, 2'd1, 16'h0000, 1'b1));
    repeat (2) send_request(select_req());
    settle_block();
  endtask

  // well-formed bursts: fill, sometimes past full, then drain past empty
  task automatic test_fill_and_drain(input int bursts);
    int depth;
    repeat (bursts) begin
      depth = $urandom_range(1, DEF_TABLE_DEPTH + 2);
      repeat (depth) begin
        if ($urandom_range(0, 9) == 0) send_request(random_request(0, 100));
        send_request(random_request(100, 0));
      end
      repeat (depth + 1) send_request(select_req());
    end
    settle_block();
  endtask

  task automatic test_granularity_sweep();
    write_min_gran(8'd0);
    send_random_mix(230, 50, 10);
    write_min_gran(8'd255);
    send_random_mix(230, 50, 10);
    write_min_gran(GRAN_W'($urandom_range(1, 254)));
    send_random_mix(230, 45, 10);
    write_min_gran(MIN_GRAN_RESET);
    send_random_mix(200, 55, 10);
    settle_block();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_result_backpressure();
    rx_hold_len = HOLD_CYCLES;
    tx_calm     = 1'b1;
    send_random_mix(40, 50, 0);
    tx_calm     = 1'b0;
    settle_block();
  endtask

  // back-to-back on both sides
  task automatic test_full_rate();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    send_random_mix(150, 50, 5);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    settle_block();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_picks();
    test_fill_and_drain(12);
    test_result_backpressure();
    test_granularity_sweep();
    test_full_rate();
    settle_block();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
